>>> sv/ccrs_pkg.sv
package ccrs_pkg;

	// Default sizing of the scanner
	localparam int MAX_CELLS_DEF     = 64;
	localparam int POSITION_BITS_DEF = 24;
	localparam int ROW_BITS_DEF      = 20;

	// Field widths of the result item
	localparam int CELLS_OUT_W = 7;
	localparam int ROW_OUT_W   = 20;
	localparam int POS_OUT_W   = 24;

	// Configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_DELIMITER       = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_FIRST_ROW_NAMES = 1'd1;
	localparam logic [7:0] DELIMITER_RESET = 8'd44;

	// Row terminator bytes
	localparam logic [7:0] CHAR_NL  = 8'h0A;
	localparam logic [7:0] CHAR_NUL = 8'h00;

	// Status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_WIDTH    = 2'd1;
	localparam logic [1:0] ST_TOO_MANY = 2'd2;

	typedef struct packed {
		logic [7:0] delimiter;
		logic       first_row_names;
	} ccrs_cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_last;
	} ccrs_in_t;

	typedef struct packed {
		logic [7:0]             out_byte;
		logic                   cell_end;
		logic                   row_end;
		logic [CELLS_OUT_W-1:0] row_cells;
		logic [ROW_OUT_W-1:0]   row_number;
		logic                   trailing_delimiter;
		logic [1:0]             status;
		logic                   done_res;
		logic [ROW_OUT_W-1:0]   total_rows;
		logic [CELLS_OUT_W-1:0] total_columns;
		logic [POS_OUT_W-1:0]   header_length;
		logic                   no_separator_warning;
	} ccrs_out_t;

endpackage

>>> sv/ccrs_cfg_regs.sv
module ccrs_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ccrs_pkg::PADDR_W-1:0]  paddr,
	input  logic [ccrs_pkg::PDATA_W-1:0]  pwdata,
	output logic [ccrs_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output ccrs_pkg::ccrs_cfg_t           cfg
);
	import ccrs_pkg::*;

	ccrs_cfg_t              cfg_q;
	logic [REG_IDX_W-1:0]   reg_idx;
	logic                   wr_en;

	assign reg_idx = paddr[PADDR_W-1:2];
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// Write the addressed register on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delimiter       <= DELIMITER_RESET;
			cfg_q.first_row_names <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_DELIMITER:       cfg_q.delimiter       <= pwdata[7:0];
				REG_FIRST_ROW_NAMES: cfg_q.first_row_names <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Return the addressed register
	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_DELIMITER:       prdata = {{(PDATA_W-8){1'b0}}, cfg_q.delimiter};
			REG_FIRST_ROW_NAMES: prdata = {{(PDATA_W-1){1'b0}}, cfg_q.first_row_names};
			default:             prdata = '0;
		endcase
	end

endmodule

>>> sv/ccrs_scan_core.sv
module ccrs_scan_core #(
	parameter int MAX_CELLS     = ccrs_pkg::MAX_CELLS_DEF,
	parameter int POSITION_BITS = ccrs_pkg::POSITION_BITS_DEF,
	parameter int ROW_BITS      = ccrs_pkg::ROW_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ccrs_pkg::ccrs_cfg_t  cfg,
	input  logic                 step,
	input  ccrs_pkg::ccrs_in_t   item,
	output ccrs_pkg::ccrs_out_t  result
);
	import ccrs_pkg::*;

	localparam int CW = $clog2(MAX_CELLS + 1);
	localparam int PB = POSITION_BITS;
	localparam int RB = ROW_BITS;
	localparam logic [CW-1:0] CELLS_LIMIT = CW'(MAX_CELLS);

	// Scan state
	logic [PB-1:0] byte_pos_q;
	logic [CW-1:0] cells_q;
	logic [CW-1:0] expected_q;
	logic [RB-1:0] rows_q;
	logic          after_delim_q;
	logic [PB-1:0] name_len_q;
	logic [1:0]    error_q;
	logic          seen_q;

	logic [PB-1:0] byte_pos_n;
	logic [CW-1:0] cells_n;
	logic [CW-1:0] expected_n;
	logic [RB-1:0] rows_n;
	logic          after_delim_n;
	logic [PB-1:0] name_len_n;
	logic [1:0]    error_n;
	logic          seen_n;

	logic [7:0]    b;
	logic          last;
	logic          is_term;
	logic          is_delim;
	logic          full;
	logic [CW-1:0] cells_p1;
	logic [PB:0]   pos_p1;
	logic [PB:0]   pos_p2;
	logic [7:0]    ob;
	logic          ce;
	logic          re;
	logic          tr;
	logic [CW-1:0] rc;
	logic          fin;
	logic [CW-1:0] fin_cells;
	logic [PB:0]   fin_pos;
	logic [PB-1:0] fin_pos_sat;

	assign b        = item.data_byte;
	assign last     = item.is_last;
	assign is_term  = (b == CHAR_NL) || (b == CHAR_NUL);
	assign is_delim = (b == cfg.delimiter);
	assign full     = (cells_q >= CELLS_LIMIT);
	assign cells_p1 = cells_q + 1'b1;
	assign pos_p1   = {1'b0, byte_pos_q} + 1'b1;
	assign pos_p2   = {1'b0, byte_pos_q} + 2'd2;
	assign fin_pos_sat = fin_pos[PB] ? {PB{1'b1}} : fin_pos[PB-1:0];

	// Classify the byte and work out the next state
	always_comb begin
		ob            = b;
		ce            = 1'b0;
		re            = 1'b0;
		tr            = 1'b0;
		rc            = '0;
		fin           = 1'b0;
		fin_cells     = cells_q;
		fin_pos       = pos_p1;
		cells_n       = cells_q;
		expected_n    = expected_q;
		rows_n        = rows_q;
		after_delim_n = after_delim_q;
		name_len_n    = name_len_q;
		error_n       = error_q;

		if (error_q == ST_OK) begin
			if (after_delim_q && is_term) begin
				// trailing delimiter: terminator kept, no extra cell
				re  = 1'b1;
				tr  = 1'b1;
				rc  = cells_q;
				fin = 1'b1;
			end else if (is_delim) begin
				if (full) begin
					error_n = ST_TOO_MANY;
				end else begin
					ob            = CHAR_NUL;
					ce            = 1'b1;
					cells_n       = cells_p1;
					after_delim_n = 1'b1;
					if (last) begin
						re        = 1'b1;
						tr        = 1'b1;
						rc        = cells_p1;
						fin       = 1'b1;
						fin_cells = cells_p1;
						fin_pos   = pos_p2;
					end
				end
			end else if (is_term) begin
				if (full) begin
					error_n = ST_TOO_MANY;
				end else begin
					ob        = CHAR_NUL;
					ce        = 1'b1;
					re        = 1'b1;
					rc        = cells_p1;
					fin       = 1'b1;
					fin_cells = cells_p1;
				end
			end else begin
				after_delim_n = 1'b0;
				if (last) begin
					if (full) begin
						error_n = ST_TOO_MANY;
					end else begin
						// virtual terminator closes the cell and row
						ce        = 1'b1;
						re        = 1'b1;
						rc        = cells_p1;
						fin       = 1'b1;
						fin_cells = cells_p1;
						fin_pos   = pos_p2;
					end
				end
			end

			// Complete the row and check its width against the first row
			if (fin) begin
				if ((rows_q == '0) && cfg.first_row_names)
					name_len_n = fin_pos_sat;
				cells_n       = '0;
				after_delim_n = 1'b0;
				if ((expected_q != '0) && (expected_q != fin_cells)) begin
					error_n = ST_WIDTH;
				end else begin
					expected_n = fin_cells;
					if (rows_q != {RB{1'b1}})
						rows_n = rows_q + 1'b1;
				end
			end
		end

		seen_n     = seen_q | ((error_q == ST_OK) && (ob == CHAR_NUL));
		byte_pos_n = pos_p1[PB] ? {PB{1'b1}} : pos_p1[PB-1:0];
	end

	// Build the result item
	always_comb begin
		result                      = '0;
		result.out_byte             = ob;
		result.cell_end             = ce;
		result.row_end              = re;
		result.row_cells            = CELLS_OUT_W'(rc);
		result.row_number           = ROW_OUT_W'(rows_q);
		result.trailing_delimiter   = tr;
		result.status               = error_n;
		result.done_res             = last;
		if (last && (error_n == ST_OK)) begin
			result.total_rows           = ROW_OUT_W'(rows_n);
			result.total_columns        = CELLS_OUT_W'(expected_n);
			result.header_length        = POS_OUT_W'(name_len_n);
			result.no_separator_warning = ~seen_n;
		end
	end

	// Advance the state; clear it after the last byte of a file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q    <= '0;
			cells_q       <= '0;
			expected_q    <= '0;
			rows_q        <= '0;
			after_delim_q <= 1'b0;
			name_len_q    <= '0;
			error_q       <= ST_OK;
			seen_q        <= 1'b0;
		end else if (step) begin
			if (last) begin
				byte_pos_q    <= '0;
				cells_q       <= '0;
				expected_q    <= '0;
				rows_q        <= '0;
				after_delim_q <= 1'b0;
				name_len_q    <= '0;
				error_q       <= ST_OK;
				seen_q        <= 1'b0;
			end else begin
				byte_pos_q    <= byte_pos_n;
				cells_q       <= cells_n;
				expected_q    <= expected_n;
				rows_q        <= rows_n;
				after_delim_q <= after_delim_n;
				name_len_q    <= name_len_n;
				error_q       <= error_n;
				seen_q        <= seen_n;
			end
		end
	end

endmodule

>>> sv/csv_cell_row_scanner.sv
// CSV cell and row scanner. Takes one file byte per item on the byte channel
// and returns one result item per byte on the scan channel, one byte per
// cycle sustained while scan_stall is low; each byte passes through an input
// register and a result register with the scan logic between them.
// Delimiters and row terminators (newline, NUL) come out as zero with cell and
// row flags, except a terminator after a trailing delimiter, which is kept;
// each row's cell count is checked against the first row and against
// MAX_CELLS. The item for the byte marked is_last carries done_res, the totals,
// the header length and the no-separator warning, and the scan state is then
// cleared so that the next file may follow at once. Write the delimiter and
// first_row_names registers over the APB port only while no item is in flight.
module csv_cell_row_scanner #(
	parameter int MAX_CELLS     = ccrs_pkg::MAX_CELLS_DEF,
	parameter int POSITION_BITS = ccrs_pkg::POSITION_BITS_DEF,
	parameter int ROW_BITS      = ccrs_pkg::ROW_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          byte_valid,
	output logic                          byte_stall,
	input  ccrs_pkg::ccrs_in_t            byte_item,
	output logic                          scan_valid,
	input  logic                          scan_stall,
	output ccrs_pkg::ccrs_out_t           scan_result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ccrs_pkg::PADDR_W-1:0]  paddr,
	input  logic [ccrs_pkg::PDATA_W-1:0]  pwdata,
	output logic [ccrs_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import ccrs_pkg::*;

	ccrs_cfg_t cfg;
	ccrs_in_t  item_s1;
	logic      vld_s1;
	ccrs_out_t res_s2;
	logic      vld_s2;
	ccrs_out_t result;
	logic      advance;
	logic      take;

	ccrs_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ccrs_scan_core #(
		.MAX_CELLS     (MAX_CELLS),
		.POSITION_BITS (POSITION_BITS),
		.ROW_BITS      (ROW_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (vld_s1 & advance),
		.item   (item_s1),
		.result (result)
	);

	// Move the item on when the result register is free or being emptied
	assign advance    = ~vld_s2 | ~scan_stall;
	assign byte_stall = vld_s1 & ~advance;
	assign take       = byte_valid & ~byte_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			item_s1 <= byte_item;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && vld_s1)
			res_s2 <= result;
	end

	assign scan_valid  = vld_s2;
	assign scan_result = res_s2;

	// A result appears only for an item that sat in the input register
	a_result_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(vld_s2) |-> $past(vld_s1))
		else $error("result appeared without an input item");

	// Totals are reported only on the last byte of a file
	a_totals_at_done: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_valid && !scan_result.done_res) |->
		(scan_result.total_rows == '0 && scan_result.total_columns == '0 &&
		 scan_result.header_length == '0 && !scan_result.no_separator_warning))
		else $error("totals reported before the end of the file");

	// A trailing delimiter is only flagged on a completed row
	a_trailing_row: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_valid && scan_result.trailing_delimiter) |-> scan_result.row_end)
		else $error("trailing delimiter without row end");

	// A row ends either on a closing cell or after a trailing delimiter
	a_row_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_valid && scan_result.row_end) |->
		(scan_result.cell_end || scan_result.trailing_delimiter))
		else $error("row ended without closing a cell");

endmodule
